>>> design/ttcw_pkg.sv
// Shared types and constants for the text terminal character writer.
// Depends on nothing; imported by ttcw_ctrl, the top level and the testbench.
package ttcw_pkg;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WIPE,
    ST_DONE
  } ttcw_state_t;

  typedef struct packed {
    logic [5:0] cursor_col;
    logic [5:0] cursor_row;
    logic [5:0] view_row;
    logic [5:0] oldest_row;
    logic       cursor_visible;
    logic [7:0] cell_char;
  } ttcw_result_t;

endpackage

>>> design/text_terminal_char_writer.sv
// Text terminal character writer: character store RAM, sequencer and output register.
// Depends on ttcw_pkg, ttcw_ram and ttcw_ctrl.
//
// Input beats (in_valid, in_stall) carry kind, char_code, read_col and read_row.
// A character beat updates the cursor and the store, a tick beat toggles the
// cursor flag, an in-range read beat fetches one cell. Each input beat gives
// exactly one output beat (out_valid, out_stall) with the cursor state after the
// item and the cell read, or zero for items that are not in-range reads.
// The block takes one item at a time and holds in_stall high while it works.
// Each item's result waits in the DONE state until it is loaded into the output
// register; an in-range read passes through the READ state first, since the store
// has a registered read port. A newline that reaches the oldest row passes through
// the WIPE state first, which fills that row with spaces one cell per cycle.
// A result waiting in the output register does not keep the block from
// accepting the next item; that item's result then waits in the sequencer,
// with in_stall high, until out_stall falls.
// After reset the sequencer writes zero to every word of the store, one word
// per cycle, 2**(clog2(ROWS) + clog2(COLUMNS)) words (4096 at the default
// size), holding in_stall high until it is done.
module text_terminal_char_writer #(
  parameter int COLUMNS = 40,
  parameter int ROWS    = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [7:0] char_code,
  input  logic [5:0] read_col,
  input  logic [5:0] read_row,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] cursor_col,
  output logic [5:0] cursor_row,
  output logic [5:0] view_row,
  output logic [5:0] oldest_row,
  output logic       cursor_visible,
  output logic [7:0] cell_char
);
  import ttcw_pkg::*;

  localparam int AW    = $clog2(ROWS) + $clog2(COLUMNS);
  localparam int DEPTH = 1 << AW;

  ttcw_result_t  res;
  logic          res_valid;
  logic          slot_free;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  assign slot_free = !out_valid || !out_stall;

  ttcw_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  ttcw_ctrl #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS),
    .AW     (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .char_code(char_code),
    .read_col (read_col),
    .read_row (read_row),
    .slot_free(slot_free),
    .res_valid(res_valid),
    .res      (res),
    .mem_we   (mem_we),
    .mem_addr (mem_addr),
    .mem_wdata(mem_wdata),
    .mem_rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && slot_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_valid && slot_free) begin
      cursor_col     <= res.cursor_col;
      cursor_row     <= res.cursor_row;
      view_row       <= res.view_row;
      oldest_row     <= res.oldest_row;
      cursor_visible <= res.cursor_visible;
      cell_char      <= res.cell_char;
    end
  end

endmodule

>>> design/ttcw_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Depends on nothing.
module ttcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/ttcw_ctrl.sv
// Sequencer of the text terminal: cursor registers, clearing pass, line wipe
// and write and read access to the character store. Depends on ttcw_pkg.
module ttcw_ctrl #(
  parameter int COLUMNS = 40,
  parameter int ROWS    = 64,
  parameter int AW      = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            kind,
  input  logic [7:0]            char_code,
  input  logic [5:0]            read_col,
  input  logic [5:0]            read_row,
  input  logic                  slot_free,
  output logic                  res_valid,
  output ttcw_pkg::ttcw_result_t res,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_addr,
  output logic [7:0]            mem_wdata,
  input  logic [7:0]            mem_rdata
);
  import ttcw_pkg::*;

  localparam int CW  = $clog2(COLUMNS);
  localparam int CCW = $clog2(COLUMNS + 1);
  localparam int RW  = $clog2(ROWS);
  localparam logic [CCW-1:0] COL_MAX   = CCW'(COLUMNS);
  localparam logic [CCW-1:0] COL_LAST  = CCW'(COLUMNS - 1);
  localparam logic [CW-1:0]  WIPE_LAST = CW'(COLUMNS - 1);
  localparam logic [RW-1:0]  ROW_LAST  = RW'(ROWS - 1);

  ttcw_state_t    state, state_next;
  logic [CCW-1:0] col, col_next;
  logic [RW-1:0]  row, row_next;
  logic [RW-1:0]  view, view_next;
  logic [RW-1:0]  oldest, oldest_next;
  logic           blink, blink_next;
  logic [7:0]     cell_byte, cell_byte_next;
  logic [CW-1:0]  wipe_col, wipe_col_next;
  logic [AW-1:0]  clr_addr, clr_addr_next;

  logic          accept;
  logic          is_char, is_tick, is_read;
  logic          is_nl, is_cr, is_bs, is_print;
  logic          read_ok;
  logic [RW-1:0] row_inc;
  logic [RW-1:0] oldest_inc;
  logic          wraps;

  assign accept   = in_valid && !in_stall;
  assign is_char  = kind == KIND_CHAR;
  assign is_tick  = kind == KIND_TICK;
  assign is_read  = kind == KIND_READ;
  assign is_nl    = char_code == CH_NEWLINE;
  assign is_cr    = char_code == CH_RETURN;
  assign is_bs    = char_code == CH_BACKSPACE;
  assign is_print = !is_nl && !is_cr && !is_bs;
  assign read_ok  = ({3'b000, read_col} < 9'(COLUMNS)) && ({3'b000, read_row} < 9'(ROWS));
  assign row_inc    = (row == ROW_LAST) ? '0 : row + RW'(1);
  assign oldest_inc = (oldest == ROW_LAST) ? '0 : oldest + RW'(1);
  assign wraps      = row_inc == oldest;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (is_char && is_nl && wraps) begin
            state_next = ST_WIPE;
          end else if (is_read && read_ok) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_READ: begin
        state_next = ST_DONE;
      end
      ST_WIPE: begin
        if (wipe_col == WIPE_LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall  = state != ST_IDLE;
    res_valid = state == ST_DONE;
    mem_we    = 1'b0;
    mem_addr  = {row, col[CW-1:0]};
    mem_wdata = char_code;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        if (accept && is_char && is_print && (col < COL_MAX)) begin
          mem_we = 1'b1;
        end else if (accept && is_read) begin
          mem_addr = {RW'(read_row), CW'(read_col)};
        end
      end
      ST_WIPE: begin
        mem_we    = 1'b1;
        mem_addr  = {row, wipe_col};
        mem_wdata = CH_SPACE;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    col_next       = col;
    row_next       = row;
    view_next      = view;
    oldest_next    = oldest;
    blink_next     = blink;
    cell_byte_next = cell_byte;
    wipe_col_next  = wipe_col;
    clr_addr_next  = clr_addr + AW'(1);
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cell_byte_next = '0;
          if (is_char) begin
            blink_next = 1'b1;
            if (is_nl) begin
              row_next      = row_inc;
              col_next      = '0;
              view_next     = row_inc;
              wipe_col_next = '0;
              if (wraps) begin
                oldest_next = oldest_inc;
              end
            end else if (is_cr) begin
              col_next = '0;
            end else if (is_bs) begin
              if (col inside {CCW'(0), COL_MAX}) begin
                col_next = COL_LAST;
              end else begin
                col_next = col - CCW'(1);
              end
            end else begin
              if (col < COL_MAX) begin
                col_next = col + CCW'(1);
              end
              view_next = row;
            end
          end else if (is_tick) begin
            blink_next = !blink;
          end
        end
      end
      ST_READ: begin
        cell_byte_next = mem_rdata;
      end
      ST_WIPE: begin
        wipe_col_next = wipe_col + CW'(1);
      end
      default: begin
        cell_byte_next = cell_byte;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      col      <= '0;
      row      <= '0;
      view     <= '0;
      oldest   <= RW'(1);
      blink    <= 1'b1;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      col      <= col_next;
      row      <= row_next;
      view     <= view_next;
      oldest   <= oldest_next;
      blink    <= blink_next;
      clr_addr <= clr_addr_next;
    end
    cell_byte <= cell_byte_next;
    wipe_col  <= wipe_col_next;
  end

  assign res.cursor_col     = 6'(col);
  assign res.cursor_row     = 6'(row);
  assign res.view_row       = 6'(view);
  assign res.oldest_row     = 6'(oldest);
  assign res.cursor_visible = blink;
  assign res.cell_char      = cell_byte;

endmodule

>>> design/ttcw_checker.sv
// Port-level checks for the text terminal character writer, bound to its top level.
// Depends only on the top level's ports.
module ttcw_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [5:0] cursor_col,
  input logic [7:0] cell_char
);

  // Reset starts the clearing pass, so no beat is taken right after it.
  a_reset_stalls: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken right after reset");

  // Items are handled one at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item accepted while one is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(cursor_col) && $stable(cell_char)))
    else $error("stalled output beat changed");

endmodule

bind text_terminal_char_writer ttcw_checker u_ttcw_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .cursor_col(cursor_col),
  .cell_char (cell_char)
);

>>> tb/text_terminal_char_writer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for text_terminal_char_writer: directed table, then random
// console traffic under three idle/stall mixes, results checked by table or predictor.
// Depends on ttcw_pkg and the design files only.
module text_terminal_char_writer_tb;
  import ttcw_pkg::*;

  localparam int COLUMNS = 40;
  localparam int ROWS = 64;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1880;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DIRECTED_STEPS = 23;
  localparam ttcw_result_t PREDICTED = '0;

  typedef struct packed {
    logic [1:0]   k;
    logic [7:0]   c;
    logic [5:0]   rc;
    logic [5:0]   rr;
    logic         typed;
    ttcw_result_t want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] kind = KIND_CHAR;
  logic [7:0] char_code = 8'h00;
  logic [5:0] read_col = 6'd0;
  logic [5:0] read_row = 6'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] cursor_col;
  logic [5:0] cursor_row;
  logic [5:0] view_row;
  logic [5:0] oldest_row;
  logic cursor_visible;
  logic [7:0] cell_char;

  logic [7:0] shadow_text [0:ROWS-1][0:COLUMNS-1];
  int shadow_col = 0;
  int shadow_row = 0;
  int shadow_view = 0;
  int shadow_oldest = 1;
  logic shadow_blink = 1'b1;

  ttcw_result_t pending_results [$];
  ttcw_result_t front_result;
  step_row_t directed_steps [DIRECTED_STEPS];
  int src_idle_pct = 25;
  int snk_stall_pct = 57;
  int items_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int line_wipes = 0;
  int cell_reads = 0;
  int quiet_cycles = 0;

  text_terminal_char_writer #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .char_code(char_code),
    .read_col(read_col),
    .read_row(read_row),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cursor_col(cursor_col),
    .cursor_row(cursor_row),
    .view_row(view_row),
    .oldest_row(oldest_row),
    .cursor_visible(cursor_visible),
    .cell_char(cell_char)
  );

  always #4 clk = ~clk;

  function automatic ttcw_result_t predict_terminal(input logic [1:0] k, input logic [7:0] c,
                                                    input logic [5:0] rc, input logic [5:0] rr);
    ttcw_result_t r;
    int j;
    r = '0;
    case (k)
      KIND_CHAR: begin
        shadow_blink = 1'b1;
        if (c == CH_NEWLINE) begin
          shadow_row = (shadow_row + 1) % ROWS;
          shadow_col = 0;
          if (shadow_row == shadow_oldest) begin
            for (j = 0; j < COLUMNS; j++) shadow_text[shadow_row][j] = CH_SPACE;
            shadow_oldest = (shadow_oldest + 1) % ROWS;
            line_wipes++;
          end
          shadow_view = shadow_row;
        end else if (c == CH_RETURN) begin
          shadow_col = 0;
        end else if (c == CH_BACKSPACE) begin
          shadow_col = (shadow_col + COLUMNS - 1) % COLUMNS;
        end else begin
          if (shadow_col < COLUMNS) begin
            shadow_text[shadow_row][shadow_col] = c;
            shadow_col++;
          end
          shadow_view = shadow_row;
        end
      end
      KIND_TICK: shadow_blink = ~shadow_blink;
      KIND_READ: begin
        if (rc < COLUMNS && rr < ROWS) begin
          r.cell_char = shadow_text[rr][rc];
          cell_reads++;
        end
      end
      default: ;
    endcase
    r.cursor_col = 6'(shadow_col);
    r.cursor_row = 6'(shadow_row);
    r.view_row = 6'(shadow_view);
    r.oldest_row = 6'(shadow_oldest);
    r.cursor_visible = shadow_blink;
    return r;
  endfunction

  // Holds the beat until it is taken; valid stays high afterwards so that the
  // next call either keeps it up or drops it with a single assignment.
  task automatic send_item(input logic [1:0] k, input logic [7:0] c, input logic [5:0] rc,
                           input logic [5:0] rr, input logic typed, input ttcw_result_t want);
    ttcw_result_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    char_code <= c;
    read_col <= rc;
    read_row <= rr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_terminal(k, c, rc, rr);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic send_mixed_item();
    int unsigned pick;
    logic [1:0] k;
    logic [7:0] c;
    logic [5:0] rc;
    pick = $urandom_range(99);
    c = 8'($urandom);
    rc = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(COLUMNS - 1));
    if (pick < 55) begin
      k = KIND_CHAR;
      case ($urandom_range(19))
        0, 1: c = CH_NEWLINE;
        2: c = CH_RETURN;
        3: c = CH_BACKSPACE;
        default: ;
      endcase
    end else if (pick < 65) begin
      k = KIND_TICK;
    end else if (pick < 95) begin
      k = KIND_READ;
    end else begin
      k = KIND_UNUSED;
    end
    send_item(k, c, rc, 6'($urandom), 1'b0, PREDICTED);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got col %0d row %0d cell %0d",
                   $time, cursor_col, cursor_row, cell_char);
          mismatches++;
        end else begin
          front_result = pending_results.pop_front();
          check_field("cursor_col", front_result.cursor_col, cursor_col);
          check_field("cursor_row", front_result.cursor_row, cursor_row);
          check_field("view_row", front_result.view_row, view_row);
          check_field("oldest_row", front_result.oldest_row, oldest_row);
          check_field("cursor_visible", front_result.cursor_visible, cursor_visible);
          check_field("cell_char", front_result.cell_char, cell_char);
          results_checked++;
        end
      end
      out_stall <= ($urandom_range(99) < snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("text_terminal_char_writer_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int target;
    int n;
    int seg;
    for (int r = 0; r < ROWS; r++)
      for (int j = 0; j < COLUMNS; j++) shadow_text[r][j] = 8'h00;
    directed_steps = '{
      '{KIND_READ, 8'h00, 6'd0, 6'd0, 1'b1, '{6'd0, 6'd0, 6'd0, 6'd1, 1'b1, 8'h00}},
      '{KIND_TICK, 8'h00, 6'd0, 6'd0, 1'b1, '{6'd0, 6'd0, 6'd0, 6'd1, 1'b0, 8'h00}},
      '{KIND_READ, 8'hFF, 6'd63, 6'd63, 1'b1, '{6'd0, 6'd0, 6'd0, 6'd1, 1'b0, 8'h00}},
      '{KIND_UNUSED, 8'hFF, 6'd63, 6'd63, 1'b1, '{6'd0, 6'd0, 6'd0, 6'd1, 1'b0, 8'h00}},
      '{KIND_CHAR, 8'hFF, 6'd0, 6'd0, 1'b1, '{6'd1, 6'd0, 6'd0, 6'd1, 1'b1, 8'h00}},
      '{KIND_CHAR, 8'h00, 6'd0, 6'd0, 1'b0, PREDICTED},
      '{KIND_READ, 8'h00, 6'd0, 6'd0, 1'b0, PREDICTED},
      '{KIND_CHAR, CH_BACKSPACE, 6'd0, 6'd0, 1'b0, PREDICTED},
      '{KIND_CHAR, CH_RETURN, 6'd0, 6'd0, 1'b0, PREDICTED},
      '{KIND_CHAR, CH_BACKSPACE, 6'd0, 6'd0, 1'b0, PREDICTED},
      '{KIND_CHAR, 8'h41, 6'd0, 6'd0, 1'b0, PREDICTED},
      '{KIND_CHAR, 8'h42, 6'd0, 6'd0, 1'b0, PREDICTED},
      '{KIND_CHAR, CH_BACKSPACE, 6'd0, 6'd0, 1'b0, PREDICTED},
      '{KIND_CHAR, CH_NEWLINE, 6'd0, 6'd0, 1'b0, PREDICTED},
      '{KIND_READ, 8'h00, 6'd39, 6'd1, 1'b0, PREDICTED},
      '{KIND_READ, 8'h00, 6'd40, 6'd1, 1'b0, PREDICTED},
      '{KIND_READ, 8'h00, 6'd39, 6'd63, 1'b0, PREDICTED},
      '{KIND_TICK, 8'h00, 6'd0, 6'd0, 1'b0, PREDICTED},
      '{KIND_CHAR, CH_NEWLINE, 6'd0, 6'd0, 1'b0, PREDICTED},
      '{KIND_CHAR, 8'h7F, 6'd0, 6'd0, 1'b0, PREDICTED},
      '{KIND_CHAR, CH_RETURN, 6'd0, 6'd0, 1'b0, PREDICTED},
      '{KIND_TICK, 8'h00, 6'd0, 6'd0, 1'b0, PREDICTED},
      '{KIND_READ, 8'h00, 6'd0, 6'd2, 1'b0, PREDICTED}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i])
      send_item(directed_steps[i].k, directed_steps[i].c, directed_steps[i].rc,
                directed_steps[i].rr, directed_steps[i].typed, directed_steps[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        src_idle_pct = 57;
        snk_stall_pct = 25;
      end else if (phase == 2) begin
        src_idle_pct = 0;
        snk_stall_pct = 0;
      end
      if (phase != 0) begin
        // The sender holds off here until the block has delivered everything.
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      target = items_sent + RANDOM_ITEMS / 3;
      while (items_sent < target) begin
        seg = $urandom_range(99);
        if (seg < 12) begin
          n = $urandom_range(COLUMNS - 2, COLUMNS + 5);
          repeat (n) send_item(KIND_CHAR, 8'($urandom_range(32, 126)), 6'($urandom),
                               6'($urandom), 1'b0, PREDICTED);
          send_item(KIND_CHAR, CH_NEWLINE, 6'($urandom), 6'($urandom), 1'b0, PREDICTED);
        end else if (seg < 20) begin
          n = $urandom_range(1, 20);
          repeat (n) send_item(KIND_CHAR, CH_NEWLINE, 6'($urandom), 6'($urandom), 1'b0,
                               PREDICTED);
        end else begin
          repeat (20) send_mixed_item();
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (COLUMNS + 24) @(posedge clk);

    $display("Sent %0d items under three idle mixes; %0d results checked, %0d in-range reads,",
             items_sent, results_checked, cell_reads);
    $display("%0d oldest-row wipes as the line ring wrapped.", line_wipes);
    if (mismatches == 0) begin
      $display("text_terminal_char_writer_tb OK");
    end else begin
      $display("text_terminal_char_writer_tb NOT OK");
    end
    $finish;
  end

endmodule
